// File: rtl/core/piecewise_linear_interpolator_unit_macros.svh
// Assertion macros for the piecewise linear interpolator.
// Included by the top level; depends on nothing.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define PLI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define PLI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/pli_pkg.sv
// Package for the piecewise linear interpolator.
// Holds commands, status codes, sequencer states and the cell link type.
package pli_pkg;
    localparam int MaxPointsDefault = 64;
    localparam int DataW = 32;
    localparam int CountW = 7;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_PICK, S_MUL, S_DIV, S_DONE
    } seq_state_t;

    // Data travelling along the cell chain.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } link_t;
endpackage

// File: rtl/core/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator: cell chain plus sequencer.
// Depends on pli_pkg, pli_cell, pli_div and the assertion macro header.
//
//  channel | valid    | stall    | payload
//  in      | in_valid | in_stall | cmd, x_value, y_value
//  out     | out_valid| out_stall| y_result, status, point_count
//
// Clear, append, unused commands and queries on fewer than two points go from the
// idle state through the done state to the output register.
// Other queries rotate the ring once through the cell chain, pick the segment,
// multiply into the bit-serial divider, divide and settle in the done state.
// Reset clears the fill count and the sequencer; cells hold no reset.
// Hold in_stall from the accepted word until its result has left the output.
module piecewise_linear_interpolator_unit
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] y_result,
    output logic [1:0]         status,
    output logic [CountW-1:0]  point_count
);
`include "piecewise_linear_interpolator_unit_macros.svh"

    localparam int IdxW = $clog2(MAX_POINTS + 1);

    seq_state_t state_reg, state_next;
    logic [IdxW-1:0] count_reg, count_next;
    logic [IdxW-1:0] step_reg, step_next;
    logic            out_valid_reg;
    logic signed [31:0] yres_reg;
    logic [1:0]      status_reg;

    logic [1:0]         cmd_reg;
    logic signed [31:0] qx_reg;

    // Scan tracking
    logic               found_reg;   // right point found
    logic               have_l_reg;
    logic signed [31:0] xl_reg, yl_reg, xr_reg, yr_reg, x0_reg, xlast_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg, ts_reg;
    logic [31:0]        dx_reg;

    link_t chain [MAX_POINTS+1];
    link_t chain_in;
    logic  shift;
    link_t tail;

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;

    // Chain: cell 0 takes new points or the recirculated tail.
    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++)
        begin : g_cell
            pli_cell u_cell (
                .clk  (clk),
                .shift(shift),
                .din  (chain[g]),
                .dout (chain[g+1])
            );
        end
    endgenerate

    // Appends push at the front; the ring rotates all MAX_POINTS cells on a query,
    // so the oldest valid point reaches cell count-1 then the tail after shifts.
    assign tail = chain[MAX_POINTS];

    // Loading: append shifts the whole chain so element k sits at cell count-1-k.
    // For a query, tail order: after (MAX_POINTS - count) rotations the oldest point
    // is at the tail; scan the next count tail values in order.
    always_comb
    begin
        chain_in = tail;
        if (state_reg == S_IDLE)
        begin
            chain_in.x = x_value;
            chain_in.y = y_value;
        end
    end

    assign chain[0] = chain_in;

    // Query scan window: step counts rotations; tail index k = step-(MAX-count).
    logic [IdxW:0] skip;
    logic in_win;
    assign skip   = (IdxW+1)'(MAX_POINTS) - {1'b0, count_reg};
    assign in_win = ({1'b0, step_reg} >= skip);
    logic first_el, last_el;
    assign first_el = ({1'b0, step_reg} == skip);
    assign last_el  = ({1'b0, step_reg} == (IdxW+1)'(MAX_POINTS - 1));

    always_comb
    begin
        shift = 1'b0;
        if (state_reg == S_IDLE && accept_in && cmd == CMD_APPEND
            && count_reg < IdxW'(MAX_POINTS))
        begin
            shift = 1'b1;
        end
        if (state_reg == S_SHIFT && cmd_reg == CMD_QUERY)
        begin
            shift = 1'b1;
        end
    end

    // Datapath signals
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [63:0] prod;
    logic signed [32:0] dy_s, dxs, ts;
    logic [31:0] mag;
    logic        out_of_range, trivial;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    if (cmd == CMD_QUERY && count_reg >= IdxW'(2))
                        state_next = S_SHIFT;
                    else
                        state_next = S_DONE;
                end
            end
            S_SHIFT: if (last_el) state_next = S_PICK;
            S_PICK:  state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // |yr - yl| is at most 2^32 - 1, so the magnitude fits 32 bits.
    assign dy_s = {yr_reg[31], yr_reg} - {yl_reg[31], yl_reg};
    assign dxs  = {xr_reg[31], xr_reg} - {xl_reg[31], xl_reg};
    assign ts   = {qx_reg[31], qx_reg} - {xl_reg[31], xl_reg};
    assign mag  = dy_s[32] ? 32'(-dy_s) : dy_s[31:0];
    assign prod = 64'(mag_reg) * 64'(ts_reg);
    assign out_of_range = (qx_reg < x0_reg) || (qx_reg > xlast_reg);
    assign trivial = !found_reg || (xr_reg == xl_reg);
    assign div_start = (state_reg == S_MUL);

    pli_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(prod),
        .divisor (dx_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_comb
    begin
        count_next = count_reg;
        step_next  = step_reg;
        if (state_reg == S_IDLE && accept_in)
        begin
            step_next = '0;
            if (cmd == CMD_CLEAR)
                count_next = '0;
            else if (cmd == CMD_APPEND && count_reg < IdxW'(MAX_POINTS))
                count_next = count_reg + IdxW'(1);
        end
        else if (state_reg == S_SHIFT)
        begin
            step_next = step_reg + IdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (state_reg == S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept_in)
        begin
            cmd_reg    <= cmd;
            qx_reg     <= x_value;
            found_reg  <= 1'b0;
            have_l_reg <= 1'b0;
            yres_reg   <= '0;
            if (cmd == CMD_APPEND && count_reg >= IdxW'(MAX_POINTS))
                status_reg <= ST_FULL;
            else if (cmd == CMD_QUERY && count_reg < IdxW'(2))
                status_reg <= ST_RANGE;
            else
                status_reg <= ST_OK;
        end
        if (state_reg == S_SHIFT && in_win)
        begin
            if (first_el)
                x0_reg <= tail.x;
            if (last_el)
                xlast_reg <= tail.x;
            // Left point: latest before the first point above the query.
            if (!found_reg)
            begin
                if (have_l_reg && tail.x > qx_reg)
                begin
                    found_reg <= 1'b1;
                    xr_reg    <= tail.x;
                    yr_reg    <= tail.y;
                end
                else if (!have_l_reg || !(tail.x > qx_reg))
                begin
                    if (!(have_l_reg && tail.x > qx_reg))
                    begin
                        have_l_reg <= 1'b1;
                        xl_reg     <= tail.x;
                        yl_reg     <= tail.y;
                    end
                end
            end
        end
        if (state_reg == S_PICK)
        begin
            neg_reg <= dy_s[32];
            dx_reg  <= dxs[31:0];
            mag_reg <= mag;
            ts_reg  <= ts[31:0];
        end
        if (state_reg == S_DIV && div_done)
        begin
            if (out_of_range)
            begin
                status_reg <= ST_RANGE;
                yres_reg   <= '0;
            end
            else if (trivial)
                yres_reg <= yl_reg;
            else if (neg_reg)
                yres_reg <= yl_reg - div_q[31:0];
            else
                yres_reg <= yl_reg + div_q[31:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign y_result    = yres_reg;
    assign status      = status_reg;
    assign point_count = CountW'(count_reg);

    `PLI_ASSERT_IMP(a_stall_busy, out_valid_reg, in_stall, "input taken with result pending")
    `PLI_ASSERT_IMP(a_count_max, 1'b1, count_reg <= IdxW'(MAX_POINTS), "count above table size")
    `PLI_ASSERT_NXT(a_done_out, state_reg == S_DONE, out_valid_reg, "result not presented")
endmodule

// File: rtl/core/pli_cell.sv
// One breakpoint cell of the chain; holds an (x, y) pair.
// Depends on pli_pkg.
module pli_cell
    import pli_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  link_t din,
    output link_t dout
);
    link_t data_reg;

    // Payload only: validity of entries is tracked by the fill count.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;
endmodule

// File: rtl/core/pli_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 bits unsigned.
// Depends on pli_pkg.
module pli_div
    import pli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == 7'd1);
    assign quotient = quo_next;
endmodule

// File: bench/piecewise_linear_interpolator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the piecewise linear interpolator: directed and random words,
// checked against an in-bench breakpoint table model. Depends on pli_pkg and the RTL.
module piecewise_linear_interpolator_unit_tb;
    import pli_pkg::*;

    localparam int  TablePoints = 64;
    localparam longint CycleLimit = 2000000;

    typedef struct {
        logic signed [31:0] y;
        status_t            st;
        logic [6:0]         cnt;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_NONE;
    logic signed [31:0] x_value = '0;
    logic signed [31:0] y_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] y_result;
    logic [1:0]         status;
    logic [6:0]         point_count;

    // Model state: the breakpoint table as the block should hold it.
    logic signed [31:0] table_x [TablePoints];
    logic signed [31:0] table_y [TablePoints];
    int                 table_len = 0;
    answer_t            pending_answers [$];
    int                 mismatch_count = 0;
    longint             cycle_count = 0;
    bit                 hold_off = 1'b0;

    always #1 clk = ~clk;

    piecewise_linear_interpolator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .x_value(x_value), .y_value(y_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .y_result(y_result), .status(status), .point_count(point_count)
    );

    // Interpolate between the segment ends the way the scan picks them.
    function automatic logic signed [31:0] interp_at(logic signed [31:0] xq);
        int                  left;
        logic signed [63:0]  xl, xr, yl, yr, dx, dy, t, res;
        logic [63:0]         mag, q;
        left = 0;
        for (int i = 0; i < table_len; i++)
        begin
            if (table_x[i] > xq)
                break;
            left = i;
        end
        if (left + 1 >= table_len)
            return table_y[left];
        xl = table_x[left];
        xr = table_x[left + 1];
        yl = table_y[left];
        yr = table_y[left + 1];
        if (xr == xl)
            return yl[31:0];
        dx = xr - xl;
        dy = yr - yl;
        t = 64'(xq) - xl;
        if (dx < 0 || t < 0)
            return yl[31:0];
        mag = (dy < 0) ? 64'(-dy) : 64'(dy);
        q = (mag * 64'(t)) / 64'(dx);
        res = (dy < 0) ? yl - $signed(q) : yl + $signed(q);
        return res[31:0];
    endfunction

    // Advance the table model by one word and queue its answer.
    function automatic void apply_word(cmd_t c, logic signed [31:0] xv, logic signed [31:0] yv);
        answer_t a;
        a.y = '0;
        a.st = ST_OK;
        case (c)
            CMD_CLEAR: table_len = 0;
            CMD_APPEND:
                if (table_len >= TablePoints)
                    a.st = ST_FULL;
                else
                begin
                    table_x[table_len] = xv;
                    table_y[table_len] = yv;
                    table_len++;
                end
            CMD_QUERY:
                if (table_len < 2 || xv < table_x[0] || xv > table_x[table_len - 1])
                    a.st = ST_RANGE;
                else
                    a.y = interp_at(xv);
            default: ;
        endcase
        a.cnt = 7'(table_len);
        pending_answers.insert(pending_answers.size(), a);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Send one word after a random gap and wait for it to be taken.
    task automatic send_word(cmd_t c, logic signed [31:0] xv, logic signed [31:0] yv);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        x_value <= xv;
        y_value <= yv;
        apply_word(c, xv, yv);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Checker: compare each word taken from the output with the model.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                answer_t a;
                a = pending_answers.pop_front();
                if (y_result !== a.y) report_mismatch("y_result", y_result, a.y);
                if (status !== a.st) report_mismatch("status", status, a.st);
                if (point_count !== a.cnt) report_mismatch("point_count", point_count, a.cnt);
            end
        end
    end

    // Receiver: random stalls per word, plus a long hold-off on request.
    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                out_stall <= (wait_left > 0);
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(CMD_QUERY, 0, 0);                    // empty table
        send_word(CMD_APPEND, 32'sh80000000, 32'sh7fffffff);
        send_word(CMD_QUERY, 32'sh80000000, 0);        // one point only
        send_word(CMD_APPEND, 32'sh7fffffff, 32'sh80000000);
        send_word(CMD_QUERY, 32'sh80000000, 0);
        send_word(CMD_QUERY, 32'sh7fffffff, 0);        // left point is last
        send_word(CMD_QUERY, 0, 32'sh12345678);
        send_word(CMD_NONE, 5, 6);
        send_word(CMD_CLEAR, 0, 0);
        send_word(CMD_APPEND, 100, 7);
        send_word(CMD_APPEND, 100, 9);                 // equal x values
        send_word(CMD_APPEND, 300, -50);
        send_word(CMD_APPEND, 200, 1000);              // unsorted
        send_word(CMD_QUERY, 100, 0);
        send_word(CMD_QUERY, 99, 0);                   // below first
        send_word(CMD_QUERY, 250, 0);
        send_word(CMD_QUERY, 201, 0);
        send_word(CMD_QUERY, 301, 0);
        send_word(CMD_CLEAR, 0, 0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TablePoints + 2; i++)
            send_word(CMD_APPEND, i * 65536, rand_word());
        send_word(CMD_QUERY, $urandom_range(0, (TablePoints - 1) * 65536), 0);
        send_word(CMD_QUERY, (TablePoints - 1) * 65536, 0);
    endtask

    // Hold the output off long enough for the block to back up its input.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_word(i % 2 ? CMD_QUERY : CMD_APPEND, $urandom_range(0, 1000), i);
        join
    endtask

    // Mostly small sorted tables with queries inside, plus noise.
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1000)
        begin
            int n;
            logic signed [31:0] xv;
            send_word(CMD_CLEAR, rand_word(), rand_word());
            n = $urandom_range(0, 8);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(9, TablePoints + 2);
            xv = $urandom_range(0, 1) ? rand_word() : -$signed(32'($urandom_range(0, 200000)));
            for (int i = 0; i < n; i++)
            begin
                send_word(CMD_APPEND, xv, rand_word());
                if ($urandom_range(0, 7) != 0 && xv < 32'sh7fff0000)
                    xv = xv + $signed(32'($urandom_range(0, 100000)));
                else
                    xv = rand_word();
            end
            for (int i = 0; i < 8; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(cmd_t'($urandom_range(0, 3)), rand_word(), rand_word());
                else if (table_len >= 2 && $urandom_range(0, 4) != 0)
                    send_word(CMD_QUERY, $urandom_range(0, 1) ? table_x[$urandom_range(0, table_len - 1)]
                              : xv - $signed(32'($urandom_range(0, 300000))), $urandom);
                else
                    send_word(CMD_QUERY, rand_word(), $urandom);
            end
            sent += n + 9;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("piecewise_linear_interpolator_unit test passed");
        else
            $display("piecewise_linear_interpolator_unit test failed");
        $finish;
    end

    // Run limit covers slow queries, stalls and gaps with ample margin.
    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("piecewise_linear_interpolator_unit test failed");
            $finish;
        end
    end
endmodule
